// ===== rtl/tglf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tglf_pkg: shared constants, types and functions for the tile layout unit
// Widths, register indexes, microcode format and program, small grid tables.
// ----------------------------------------------------------------------------
package tglf_pkg;

  // Layout constants
  localparam int MAX_WINDOWS = 64;
  localparam int BORDER_PX   = 2;
  localparam int TITLE_PX    = 20;
  localparam int BAR_PX      = 20;
  localparam int SLOT_CAP    = (MAX_WINDOWS < 64) ? MAX_WINDOWS : 64;
  localparam int GRID_MAX    = 8;

  // Field widths
  localparam int COORD_W    = 16;
  localparam int COUNT_W    = 7;
  localparam int IDX_W      = 6;
  localparam int STEP_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Internal widths
  localparam int GRID_W  = 4;   // cols/rows 1..8
  localparam int RC_W    = 3;   // row/col position 0..7
  localparam int MV_W    = 5;   // moved row/col, signed
  localparam int SPAN_W  = 18;  // cell width/height, signed
  localparam int POS_W   = 22;  // position sums, signed
  localparam int INNER_W = 19;  // inner size before clamp, signed

  // Divider: 16-bit dividend, 4 quotient bits per pass
  localparam int DIV_W           = 16;
  localparam int DIV_RADIX_BITS  = 4;
  localparam int DIV_PASSES      = DIV_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W       = $clog2(DIV_PASSES);

  // Reset values
  localparam logic [COORD_W-1:0] RST_SCREEN_W = COORD_W'(1920);
  localparam logic [COORD_W-1:0] RST_SCREEN_H = COORD_W'(1080);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_LEFT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_TOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT= 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT = 3'd5;

  // Word opcodes and modes
  localparam logic OP_PLACE     = 1'b0;
  localparam logic OP_FOCUS     = 1'b1;
  localparam logic MODE_GRID    = 1'b0;
  localparam logic MODE_MONOCLE = 1'b1;

  // Microcode format
  localparam int UPC_W = 5;

  typedef enum logic [3:0] {
    DP_NOP        = 4'd0,
    DP_SETUP      = 4'd1,
    DP_DLOAD_SW   = 4'd2,
    DP_DLOAD_SH   = 4'd3,
    DP_DLOAD_IX   = 4'd4,
    DP_DLOAD_FC   = 4'd5,
    DP_DSTEP      = 4'd6,
    DP_SAVE_RC    = 4'd7,
    DP_MONO_LD    = 4'd8,
    DP_MUL        = 4'd9,
    DP_EMIT_PLACE = 4'd10,
    DP_EMIT_ZERO  = 4'd11,
    DP_GRID_MOVE  = 4'd12,
    DP_MONO_MOVE  = 4'd13
  } dp_op_e;

  typedef enum logic [2:0] {
    JC_NEXT     = 3'd0,
    JC_ALWAYS   = 3'd1,
    JC_NOTHING  = 3'd2,
    JC_FOCUS    = 3'd3,
    JC_MONO     = 3'd4,
    JC_HIDDEN   = 3'd5,
    JC_DIV_LOOP = 3'd6,
    JC_END      = 3'd7
  } jump_cond_e;

  typedef struct packed {
    dp_op_e             op;
    jump_cond_e         cond;
    logic [UPC_W-1:0]   target;
  } uc_word_t;

  typedef struct packed {
    logic [GRID_W-1:0] rem;
    logic [DIV_W-1:0]  acc;
  } div_state_t;

  // Program labels
  localparam logic [UPC_W-1:0] UC_ENTRY      = 5'd0;
  localparam logic [UPC_W-1:0] UC_CHK_NONE   = 5'd1;
  localparam logic [UPC_W-1:0] UC_CHK_FOCUS  = 5'd2;
  localparam logic [UPC_W-1:0] UC_CHK_MODE   = 5'd3;
  localparam logic [UPC_W-1:0] UC_LD_SW      = 5'd4;
  localparam logic [UPC_W-1:0] UC_DIV_SW     = 5'd5;
  localparam logic [UPC_W-1:0] UC_LD_SH      = 5'd6;
  localparam logic [UPC_W-1:0] UC_DIV_SH     = 5'd7;
  localparam logic [UPC_W-1:0] UC_LD_IX      = 5'd8;
  localparam logic [UPC_W-1:0] UC_DIV_IX     = 5'd9;
  localparam logic [UPC_W-1:0] UC_SAVE_RC    = 5'd10;
  localparam logic [UPC_W-1:0] UC_MUL        = 5'd11;
  localparam logic [UPC_W-1:0] UC_EMIT_PLACE = 5'd12;
  localparam logic [UPC_W-1:0] UC_MONO_CHK   = 5'd13;
  localparam logic [UPC_W-1:0] UC_MONO_LD    = 5'd14;
  localparam logic [UPC_W-1:0] UC_FOCUS      = 5'd15;
  localparam logic [UPC_W-1:0] UC_LD_FC      = 5'd16;
  localparam logic [UPC_W-1:0] UC_DIV_FC     = 5'd17;
  localparam logic [UPC_W-1:0] UC_GRID_MOVE  = 5'd18;
  localparam logic [UPC_W-1:0] UC_EMIT_ZERO  = 5'd19;
  localparam logic [UPC_W-1:0] UC_MONO_MOVE  = 5'd20;

  function automatic uc_word_t uc_rom(input logic [UPC_W-1:0] upc);
    uc_word_t w;
    w = '{DP_NOP, JC_ALWAYS, UC_EMIT_ZERO};
    unique case (upc)
      UC_ENTRY:      w = '{DP_SETUP,      JC_NEXT,     UC_ENTRY};
      UC_CHK_NONE:   w = '{DP_NOP,        JC_NOTHING,  UC_EMIT_ZERO};
      UC_CHK_FOCUS:  w = '{DP_NOP,        JC_FOCUS,    UC_FOCUS};
      UC_CHK_MODE:   w = '{DP_NOP,        JC_MONO,     UC_MONO_CHK};
      UC_LD_SW:      w = '{DP_DLOAD_SW,   JC_NEXT,     UC_ENTRY};
      UC_DIV_SW:     w = '{DP_DSTEP,      JC_DIV_LOOP, UC_DIV_SW};
      UC_LD_SH:      w = '{DP_DLOAD_SH,   JC_NEXT,     UC_ENTRY};
      UC_DIV_SH:     w = '{DP_DSTEP,      JC_DIV_LOOP, UC_DIV_SH};
      UC_LD_IX:      w = '{DP_DLOAD_IX,   JC_NEXT,     UC_ENTRY};
      UC_DIV_IX:     w = '{DP_DSTEP,      JC_DIV_LOOP, UC_DIV_IX};
      UC_SAVE_RC:    w = '{DP_SAVE_RC,    JC_NEXT,     UC_ENTRY};
      UC_MUL:        w = '{DP_MUL,        JC_NEXT,     UC_ENTRY};
      UC_EMIT_PLACE: w = '{DP_EMIT_PLACE, JC_END,      UC_ENTRY};
      UC_MONO_CHK:   w = '{DP_NOP,        JC_HIDDEN,   UC_EMIT_ZERO};
      UC_MONO_LD:    w = '{DP_MONO_LD,    JC_ALWAYS,   UC_MUL};
      UC_FOCUS:      w = '{DP_NOP,        JC_MONO,     UC_MONO_MOVE};
      UC_LD_FC:      w = '{DP_DLOAD_FC,   JC_NEXT,     UC_ENTRY};
      UC_DIV_FC:     w = '{DP_DSTEP,      JC_DIV_LOOP, UC_DIV_FC};
      UC_GRID_MOVE:  w = '{DP_GRID_MOVE,  JC_NEXT,     UC_ENTRY};
      UC_EMIT_ZERO:  w = '{DP_EMIT_ZERO,  JC_END,      UC_ENTRY};
      UC_MONO_MOVE:  w = '{DP_MONO_MOVE,  JC_ALWAYS,   UC_EMIT_ZERO};
      default: ;
    endcase
    return w;
  endfunction

  // ceil(sqrt(n)), 1 for n = 0
  function automatic logic [GRID_W-1:0] grid_cols(input logic [COUNT_W-1:0] n);
    logic [GRID_W-1:0] c;
    c = GRID_W'(GRID_MAX);
    for (int k = GRID_MAX; k >= 1; k--) begin
      if (k * k >= int'(n)) c = GRID_W'(k);
    end
    return c;
  endfunction

  // ceil(n / c): smallest r with r * c >= n
  function automatic logic [GRID_W-1:0] grid_rows(input logic [COUNT_W-1:0] n,
                                                  input logic [GRID_W-1:0]  c);
    logic [GRID_W-1:0] r;
    r = GRID_W'(GRID_MAX);
    for (int k = GRID_MAX; k >= 1; k--) begin
      if (k * int'(c) >= int'(n)) r = GRID_W'(k);
    end
    return r;
  endfunction

  // Four restoring quotient bits
  function automatic div_state_t div_pass(input div_state_t s_in,
                                          input logic [GRID_W-1:0] d);
    div_state_t       s;
    logic [GRID_W:0]  r;
    s = s_in;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      r = {s.rem, s.acc[DIV_W-1]};
      s.acc = {s.acc[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        s.acc[0] = 1'b1;
      end
      s.rem = r[GRID_W-1:0];
    end
    return s;
  endfunction

  function automatic logic [COORD_W-1:0] sat_s16(input logic signed [POS_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v < -32768) begin
      r = 16'h8000;
    end else if (v > 32767) begin
      r = 16'h7fff;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] inner_clamp(input logic signed [INNER_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v < 1) begin
      r = 16'h0001;
    end else if (v > 65535) begin
      r = 16'hffff;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tile_grid_layout_focus_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tile_grid_layout_focus_unit: window tiling and focus tracking
// Microcoded sequencer over a shared 4-bit-per-cycle divider and one adder path.
// ----------------------------------------------------------------------------
// One word is in work at a time. After a word is taken, the sequencer runs
// a grid place as three 16-bit divides by the column or row count (four
// quotient bits per cycle in the shared divider), a grid focus move as one
// divide, and a monocle place, a hidden monocle place or a monocle focus
// move with no divide; with nothing to do it goes straight to an empty
// result. The next word is taken in the cycle after the result is emitted.
// A result waits in the output register, so the sequencer stalls only when
// a new result is ready while the previous one is still stalled. No memory, no clearing pass after reset.
module tile_grid_layout_focus_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tglf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tglf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [tglf_pkg::IDX_W-1:0]       window_index_i,
  input  logic signed [tglf_pkg::STEP_W-1:0] step_x_i,
  input  logic signed [tglf_pkg::STEP_W-1:0] step_y_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [tglf_pkg::COORD_W-1:0] frame_x_o,
  output logic signed [tglf_pkg::COORD_W-1:0] frame_y_o,
  output logic [tglf_pkg::COORD_W-1:0]     inner_width_o,
  output logic [tglf_pkg::COORD_W-1:0]     inner_height_o,
  output logic                             shown_o,
  output logic [tglf_pkg::IDX_W-1:0]       focus_now_o,
  output logic                             nothing_done_o
);
  import tglf_pkg::*;

  // Configuration
  logic                       layout_mode_q;
  logic signed [COORD_W-1:0]  screen_left_q;
  logic signed [COORD_W-1:0]  screen_top_q;
  logic [COORD_W-1:0]         screen_width_q;
  logic [COORD_W-1:0]         screen_height_q;
  logic [COUNT_W-1:0]         window_count_q;

  // Sequencer
  logic                       busy_q, busy_d;
  logic [UPC_W-1:0]           upc_q, upc_d;
  uc_word_t                   uc;
  logic                       is_emit, out_free, hold, emit_fire, in_acc;

  // State
  logic [IDX_W-1:0]           focus_q, focus_d;

  // Word and datapath
  logic                       op_q;
  logic [IDX_W-1:0]           idx_q;
  logic signed [STEP_W-1:0]   step_x_q, step_y_q;
  logic [COUNT_W-1:0]         n_q;
  logic [GRID_W-1:0]          cols_q, rows_q;
  logic                       none_q;
  div_state_t                 div_q;
  logic [GRID_W-1:0]          div_d_q;
  logic [DIV_CNT_W-1:0]       div_cnt_q;
  logic                       sh_neg_q;
  logic signed [SPAN_W-1:0]   cw_q, chh_q;
  logic [RC_W-1:0]            row_q, col_q;
  logic signed [POS_W-1:0]    prod_x_q, prod_y_q;

  // Output register
  logic                       out_valid_q;
  logic signed [COORD_W-1:0]  frame_x_q, frame_y_q;
  logic [COORD_W-1:0]         inner_width_q, inner_height_q;
  logic                       shown_q, nothing_done_q;
  logic [IDX_W-1:0]           focus_now_q;

  // Combinational
  logic [COUNT_W-1:0]         n_eff;
  logic signed [SPAN_W-1:0]   sh, sy, quo_s;
  logic [DIV_W-1:0]           sh_mag;
  logic signed [POS_W-1:0]    pos_x, pos_y;
  logic signed [INNER_W-1:0]  iw_raw, ih_raw;
  logic signed [MV_W-1:0]     r_new, c_new;
  logic [COUNT_W-1:0]         move_t;
  logic                       move_ok, step_up;
  logic [IDX_W-1:0]           mono_tgt;

  assign n_eff  = (window_count_q > COUNT_W'(SLOT_CAP)) ? COUNT_W'(SLOT_CAP) : window_count_q;
  assign sh     = $signed({2'b00, screen_height_q}) - SPAN_W'(BAR_PX);
  assign sh_mag = sh[SPAN_W-1] ? DIV_W'(-sh) : DIV_W'(sh);
  assign sy     = SPAN_W'(screen_top_q) + SPAN_W'(BAR_PX);
  assign quo_s  = $signed({2'b00, div_q.acc});

  assign pos_x  = POS_W'(screen_left_q) + prod_x_q;
  assign pos_y  = POS_W'(sy) + prod_y_q;
  assign iw_raw = INNER_W'(cw_q) - INNER_W'(2 * BORDER_PX);
  assign ih_raw = INNER_W'(chh_q) - INNER_W'(TITLE_PX + BORDER_PX);

  // Grid move: quotient is the row, remainder the column
  assign r_new   = $signed({2'b00, div_q.acc[RC_W-1:0]}) + MV_W'(step_y_q);
  assign c_new   = $signed({2'b00, div_q.rem[RC_W-1:0]}) + MV_W'(step_x_q);
  assign move_t  = COUNT_W'(r_new[RC_W-1:0]) * COUNT_W'(cols_q) + COUNT_W'(c_new[RC_W-1:0]);
  assign move_ok = (r_new >= 0) && (c_new >= 0) &&
                   (r_new < $signed({1'b0, rows_q})) && (c_new < $signed({1'b0, cols_q})) &&
                   (move_t < n_q);

  // Monocle: forward if step_x > 0 or step_y < 0
  assign step_up = (step_x_q > 0) || (step_y_q < 0);
  always_comb begin
    if (step_up) begin
      mono_tgt = (COUNT_W'(focus_q) + 1'b1 == n_q) ? '0 : focus_q + 1'b1;
    end else begin
      mono_tgt = (focus_q == '0) ? IDX_W'(n_q - 1'b1) : focus_q - 1'b1;
    end
  end

  // Sequencer control
  assign uc        = uc_rom(upc_q);
  assign is_emit   = (uc.op == DP_EMIT_PLACE) || (uc.op == DP_EMIT_ZERO);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign hold      = is_emit && !out_free;
  assign emit_fire = busy_q && is_emit && out_free;
  assign in_acc    = in_valid_i && !busy_q;

  always_comb begin
    upc_d  = upc_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d = 1'b1;
        upc_d  = UC_ENTRY;
      end
    end else if (!hold) begin
      upc_d = upc_q + 1'b1;
      unique case (uc.cond)
        JC_NEXT: ;
        JC_ALWAYS: upc_d = uc.target;
        JC_NOTHING: begin
          if (none_q) upc_d = uc.target;
        end
        JC_FOCUS: begin
          if (op_q == OP_FOCUS) upc_d = uc.target;
        end
        JC_MONO: begin
          if (layout_mode_q == MODE_MONOCLE) upc_d = uc.target;
        end
        JC_HIDDEN: begin
          if (idx_q != focus_q) upc_d = uc.target;
        end
        JC_DIV_LOOP: begin
          if (div_cnt_q != DIV_CNT_W'(DIV_PASSES - 1)) upc_d = uc.target;
        end
        JC_END: busy_d = 1'b0;
      endcase
    end
  end

  always_comb begin
    focus_d = focus_q;
    if (busy_q) begin
      unique case (uc.op)
        DP_SETUP: begin
          if ((n_q != '0) && (COUNT_W'(focus_q) >= n_q)) focus_d = IDX_W'(n_q - 1'b1);
        end
        DP_GRID_MOVE: begin
          if (move_ok) focus_d = move_t[IDX_W-1:0];
        end
        DP_MONO_MOVE: focus_d = mono_tgt;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= UC_ENTRY;
      focus_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      focus_q     <= focus_d;
      out_valid_q <= emit_fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_mode_q   <= MODE_GRID;
      screen_left_q   <= '0;
      screen_top_q    <= '0;
      screen_width_q  <= RST_SCREEN_W;
      screen_height_q <= RST_SCREEN_H;
      window_count_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LAYOUT_MODE:   layout_mode_q   <= cfg_data_i[0];
        CFG_SCREEN_LEFT:   screen_left_q   <= cfg_data_i;
        CFG_SCREEN_TOP:    screen_top_q    <= cfg_data_i;
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        CFG_WINDOW_COUNT:  window_count_q  <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= op_i;
      idx_q    <= window_index_i;
      step_x_q <= step_x_i;
      step_y_q <= step_y_i;
      n_q      <= n_eff;
      cols_q   <= grid_cols(n_eff);
    end
    if (busy_q) begin
      unique case (uc.op)
        DP_SETUP: begin
          rows_q <= grid_rows(n_q, cols_q);
          none_q <= (n_q == '0) || ((op_q == OP_PLACE) && (COUNT_W'(idx_q) >= n_q));
        end
        DP_DLOAD_SW: begin
          div_q     <= '{rem: '0, acc: screen_width_q};
          div_d_q   <= cols_q;
          div_cnt_q <= '0;
        end
        DP_DLOAD_SH: begin
          cw_q      <= quo_s;
          div_q     <= '{rem: '0, acc: sh_mag};
          div_d_q   <= rows_q;
          div_cnt_q <= '0;
          sh_neg_q  <= sh[SPAN_W-1];
        end
        DP_DLOAD_IX: begin
          chh_q     <= sh_neg_q ? -quo_s : quo_s;
          div_q     <= '{rem: '0, acc: DIV_W'(idx_q)};
          div_d_q   <= cols_q;
          div_cnt_q <= '0;
        end
        DP_DLOAD_FC: begin
          div_q     <= '{rem: '0, acc: DIV_W'(focus_q)};
          div_d_q   <= cols_q;
          div_cnt_q <= '0;
        end
        DP_DSTEP: begin
          div_q     <= div_pass(div_q, div_d_q);
          div_cnt_q <= div_cnt_q + 1'b1;
        end
        DP_SAVE_RC: begin
          row_q <= div_q.acc[RC_W-1:0];
          col_q <= div_q.rem[RC_W-1:0];
        end
        DP_MONO_LD: begin
          cw_q  <= $signed({2'b00, screen_width_q});
          chh_q <= sh;
          row_q <= '0;
          col_q <= '0;
        end
        DP_MUL: begin
          prod_x_q <= POS_W'($signed({1'b0, col_q})) * POS_W'(cw_q);
          prod_y_q <= POS_W'($signed({1'b0, row_q})) * POS_W'(chh_q);
        end
        DP_EMIT_PLACE: begin
          if (out_free) begin
            frame_x_q      <= sat_s16(pos_x);
            frame_y_q      <= sat_s16(pos_y);
            inner_width_q  <= inner_clamp(iw_raw);
            inner_height_q <= inner_clamp(ih_raw);
            shown_q        <= 1'b1;
            focus_now_q    <= focus_q;
            nothing_done_q <= 1'b0;
          end
        end
        DP_EMIT_ZERO: begin
          if (out_free) begin
            frame_x_q      <= '0;
            frame_y_q      <= '0;
            inner_width_q  <= '0;
            inner_height_q <= '0;
            shown_q        <= 1'b0;
            focus_now_q    <= focus_q;
            nothing_done_q <= none_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall_o     = busy_q;
  assign out_valid_o    = out_valid_q;
  assign frame_x_o      = frame_x_q;
  assign frame_y_o      = frame_y_q;
  assign inner_width_o  = inner_width_q;
  assign inner_height_o = inner_height_q;
  assign shown_o        = shown_q;
  assign focus_now_o    = focus_now_q;
  assign nothing_done_o = nothing_done_q;

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (busy_q && (upc_q == UC_ENTRY)))
    else $error("accepted word did not start the program");

  a_focus_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (upc_q == UC_CHK_NONE)) |-> ((n_q == '0) || (COUNT_W'(focus_q) < n_q)))
    else $error("focus not clamped below window count");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (uc.op == DP_DSTEP)) |-> (div_d_q != '0))
    else $error("divide by zero in sequencer");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (uc.op == DP_DSTEP)) |=> (div_q.rem < div_d_q))
    else $error("divider remainder not below divisor");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("result produced while sequencer idle");

endmodule
`default_nettype wire
